// File: rtl/core/wshc_pkg.sv
// ----------------------------------------------------------------------------
// wshc_pkg
// Constants and shared types for the case-folding word string hash.
// ----------------------------------------------------------------------------
package wshc_pkg;

  // Word-wise lane constants
  localparam logic [31:0] LANE_ONES    = 32'h0101_0101;
  localparam logic [31:0] LANE_HIGHS   = 32'h8080_8080;
  localparam logic [31:0] BACKSLASH_X4 = 32'h5C5C_5C5C;
  localparam logic [31:0] CASE_MASK    = 32'hDFDF_DFDF;
  localparam logic [31:0] FOLD_SUB     = 32'd45;

  // Hash multipliers, split into halves of at most 32 bits
  localparam logic [31:0] K1_LO = 32'hC4D9_6501;
  localparam logic [11:0] K1_HI = 12'hFB8;
  localparam logic [31:0] K2    = 32'h0633_D5F1;
  localparam logic [31:0] K3_LO = 32'h12AA_7333;
  localparam logic [23:0] K3_HI = 24'hAE_5028;

  localparam int unsigned MIX_W = 40;  // 64-bit product shifted right by 24

  typedef struct packed {
    logic             term;    // word holds the terminating zero byte
    logic [1:0]       nvalid;  // bytes kept before the zero
    logic [MIX_W-1:0] mix;     // (K1 * masked word) >> 24
  } fold_t;

endpackage

// File: rtl/core/wshc_in_if.sv
// ----------------------------------------------------------------------------
// wshc_in_if
// Input channel: one 32-bit little-endian string word per item.
// ----------------------------------------------------------------------------
interface wshc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] text_word;

  modport source (output valid, output text_word, input ready);
  modport sink   (input valid, input text_word, output ready);
endinterface

// File: rtl/core/wshc_out_if.sv
// ----------------------------------------------------------------------------
// wshc_out_if
// Output channel: hash and length of one finished string per item.
// ----------------------------------------------------------------------------
interface wshc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  logic [31:0] string_length;

  modport source (output valid, output hash_value, output string_length, input ready);
  modport sink   (input valid, input hash_value, input string_length, output ready);
endinterface

// File: rtl/core/wshc_fold.sv
// ----------------------------------------------------------------------------
// wshc_fold
// Folds one word (backslash adjust, case clear), finds the terminating zero
// byte and forms the K1 mix of the kept bytes.
// ----------------------------------------------------------------------------
module wshc_fold (
  input  logic [31:0]      word_i,
  output wshc_pkg::fold_t  fold_o
);

  logic [31:0] x;
  logic [31:0] detect;
  logic [31:0] folded;
  logic [31:0] zflags;
  logic [31:0] low;
  logic [31:0] keep;
  logic [31:0] masked;
  logic [63:0] kp_lo;
  logic [31:0] kp_hi;
  logic [63:0] prod;
  logic [1:0]  nvalid;

  // Borrows between lanes are part of the function: keep full-word arithmetic
  assign x      = word_i ^ wshc_pkg::BACKSLASH_X4;
  assign detect = (~x >> 7) & ((x - wshc_pkg::LANE_ONES) >> 7) & wshc_pkg::LANE_ONES;
  assign folded = (word_i - 32'(detect * wshc_pkg::FOLD_SUB)) & wshc_pkg::CASE_MASK;

  assign zflags = ~word_i & (word_i - wshc_pkg::LANE_ONES) & wshc_pkg::LANE_HIGHS;
  assign low    = zflags & (32'd0 - zflags);
  // With no zero byte, low is zero and keep is all ones
  assign keep   = low - 32'd1;
  assign masked = folded & keep;

  always_comb begin
    if (zflags[7]) begin
      nvalid = 2'd0;
    end else if (zflags[15]) begin
      nvalid = 2'd1;
    end else if (zflags[23]) begin
      nvalid = 2'd2;
    end else begin
      nvalid = 2'd3;
    end
  end

  // K1 * masked mod 2^64, split into two narrow products
  assign kp_lo = masked * wshc_pkg::K1_LO;
  assign kp_hi = masked * 32'(wshc_pkg::K1_HI);
  assign prod  = kp_lo + {kp_hi, 32'h0};

  assign fold_o.term   = (zflags != 32'd0);
  assign fold_o.nvalid = nvalid;
  assign fold_o.mix    = prod[63:64-wshc_pkg::MIX_W];

endmodule

// File: rtl/core/word_string_hash_casefold.sv
// ----------------------------------------------------------------------------
// word_string_hash_casefold
// Hashes a zero-terminated string given as 32-bit words, with case folding.
// ----------------------------------------------------------------------------
// Path: a terminating word accepted on in_i reaches out_o through the input,
//   folded-word, pre-hash and output registers.
// Throughput: one word per cycle while no terminating word waits on out_o.
// Reset: clears all stage valids, the accumulator and the byte count;
//   the accumulator and count clear again after every finished string.
module word_string_hash_casefold (
  input  logic              clk_i,
  input  logic              rst_ni,
  wshc_in_if.sink           in_i,
  wshc_out_if.source        out_o
);

  // Stage 1: input word
  logic        v1_q;
  logic [31:0] w1_q;
  // Stage 2: folded word, accumulate
  logic             v2_q;
  wshc_pkg::fold_t  f2_q;
  wshc_pkg::fold_t  fold;
  // Stage 3: pre-hash and length
  logic        v3_q;
  logic [63:0] pre3_q;
  logic [31:0] len3_q;
  // Output register
  logic        v4_q;
  logic [63:0] hash4_q;
  logic [31:0] len4_q;

  logic [63:0] acc_q, acc_d;
  logic [31:0] cnt_q, cnt_d;

  logic r1, r2, r3, r4;
  logic in_fire, a1, f2, push3;

  logic [63:0] k2_lo;
  logic [31:0] k2_hi;
  logic [63:0] s;
  logic [31:0] len2;
  logic [63:0] k3_lo;
  logic [31:0] k3_hi;
  logic [63:0] hash;

  // Elastic pipeline control
  assign r4      = !v4_q || out_o.ready;
  assign r3      = !v3_q || r4;
  assign f2      = v2_q && (!f2_q.term || r3);
  assign push3   = f2 && f2_q.term;
  assign r2      = !v2_q || f2;
  assign a1      = v1_q && r2;
  assign r1      = !v1_q || r2;
  assign in_fire = in_i.valid && r1;

  assign in_i.ready = r1;

  wshc_fold u_fold (
    .word_i (w1_q),
    .fold_o (fold)
  );

  // s = mix + K2 * acc mod 2^64
  assign k2_lo = acc_q[31:0] * wshc_pkg::K2;
  assign k2_hi = acc_q[63:32] * wshc_pkg::K2;
  assign s     = k2_lo + {k2_hi, 32'h0} + 64'(f2_q.mix);
  assign len2  = cnt_q + 32'(f2_q.nvalid);

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (f2) begin
      if (f2_q.term) begin
        acc_d = 64'd0;
        cnt_d = 32'd0;
      end else begin
        acc_d = s ^ (s >> 61);
        cnt_d = cnt_q + 32'd4;
      end
    end
  end

  // hash = pre - K3 * length mod 2^64
  assign k3_lo = len3_q * wshc_pkg::K3_LO;
  assign k3_hi = len3_q * 32'(wshc_pkg::K3_HI);
  assign hash  = pre3_q - (k3_lo + {k3_hi, 32'h0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      acc_q <= 64'd0;
      cnt_q <= 32'd0;
    end else begin
      if (r1) v1_q <= in_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= push3;
      if (r4) v4_q <= v3_q;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) w1_q <= in_i.text_word;
    if (a1) f2_q <= fold;
    if (push3) begin
      pre3_q <= s;
      len3_q <= len2;
    end
    if (v3_q && r4) begin
      hash4_q <= hash;
      len4_q  <= len3_q;
    end
  end

  assign out_o.valid         = v4_q;
  assign out_o.hash_value    = hash4_q;
  assign out_o.string_length = len4_q;

  // A finished string leaves the accumulator and count cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push3 |=> (acc_q == 64'd0) && (cnt_q == 32'd0))
    else $error("state not cleared after terminating word");

  // Each non-terminating word adds four bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f2 && !f2_q.term) |=> (cnt_q == $past(cnt_q) + 32'd4))
    else $error("byte count did not advance by four");

  // A blocked pre-hash stage must hold its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !r4) |=> (v3_q && $stable(pre3_q) && $stable(len3_q)))
    else $error("stage 3 dropped or changed a waiting item");

  // Output only becomes valid from a filled stage 3
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v4_q) |-> $past(v3_q))
    else $error("output valid without a stage 3 item");

endmodule

// File: tb/wshc_hash_checker.sv
// ----------------------------------------------------------------------------
// wshc_hash_checker
// Watches both channels of the case-folding string hash. Every accepted word
// runs through a bit-exact prediction of the fold and the accumulator. Each
// finished string queues one expected hash and length, and every accepted
// result is compared field by field with the oldest one in the queue.
// ----------------------------------------------------------------------------
module wshc_hash_checker (
  input  logic clk_i,
  input  logic rst_ni,
  wshc_in_if   word_i,
  wshc_out_if  digest_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] K1_FULL = {20'd0, wshc_pkg::K1_HI, wshc_pkg::K1_LO};
  localparam logic [63:0] K2_FULL = {32'd0, wshc_pkg::K2};
  localparam logic [63:0] K3_FULL = {8'd0, wshc_pkg::K3_HI, wshc_pkg::K3_LO};

  typedef struct packed {
    logic [63:0] hash;
    logic [31:0] length;
  } digest_t;

  digest_t     expected_digests[$];
  logic [63:0] string_acc;
  logic [31:0] string_bytes;
  int          failures;

  // Take 45 from every 0x5C lane the word-wise detector flags, then clear bit 5
  function automatic logic [31:0] casefold_word(logic [31:0] w);
    logic [31:0] x;
    logic [31:0] flagged;
    x       = w ^ wshc_pkg::BACKSLASH_X4;
    flagged = (~x >> 7) & ((x - wshc_pkg::LANE_ONES) >> 7) & wshc_pkg::LANE_ONES;
    return (w - wshc_pkg::FOLD_SUB * flagged) & wshc_pkg::CASE_MASK;
  endfunction

  function automatic logic [63:0] scramble_word(logic [31:0] folded);
    logic [63:0] product;
    product = K1_FULL * {32'd0, folded};
    return product >> 24;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] w;
    logic [31:0] folded;
    logic [31:0] zero_lanes;
    logic [31:0] first_zero;
    logic [31:0] kept;
    logic [63:0] sum;
    digest_t     d;
    if (!rst_ni) begin
      expected_digests.delete();
      string_acc   = '0;
      string_bytes = '0;
      failures     = 0;
    end else begin
      // Results first: a result never belongs to the word taken at the same edge
      if (digest_i.valid && digest_i.ready) begin
        if (expected_digests.size() == 0) begin
          $display("%0t: unexpected result: expected none, got hash %h length %0d",
                   $time, digest_i.hash_value, digest_i.string_length);
          failures++;
        end else begin
          d = expected_digests.pop_front();
          if (digest_i.hash_value !== d.hash) begin
            $display("%0t: hash_value mismatch: expected %h, got %h",
                     $time, d.hash, digest_i.hash_value);
            failures++;
          end
          if (digest_i.string_length !== d.length) begin
            $display("%0t: string_length mismatch: expected %0d, got %0d",
                     $time, d.length, digest_i.string_length);
            failures++;
          end
        end
      end

      if (word_i.valid && word_i.ready) begin
        w          = word_i.text_word;
        folded     = casefold_word(w);
        zero_lanes = ~w & (w - wshc_pkg::LANE_ONES) & wshc_pkg::LANE_HIGHS;
        if (zero_lanes == '0) begin
          sum          = scramble_word(folded) + K2_FULL * string_acc;
          string_acc   = sum ^ (sum >> 61);
          string_bytes = string_bytes + 32'd4;
        end else begin
          first_zero = zero_lanes & (~zero_lanes + 32'd1);
          case (first_zero)
            32'h0000_0080: kept = 32'd0;
            32'h0000_8000: kept = 32'd1;
            32'h0080_0000: kept = 32'd2;
            default:       kept = 32'd3;
          endcase
          d.length = string_bytes + kept;
          d.hash   = K2_FULL * string_acc + scramble_word(folded & (first_zero - 32'd1))
                   - K3_FULL * {32'd0, d.length};
          expected_digests.push_back(d);
          string_acc   = '0;
          string_bytes = '0;
        end
      end
    end
    fail_count_o <= failures;
    pending_o    <= expected_digests.size();
  end

endmodule

// File: tb/word_string_hash_casefold_test.sv
// ----------------------------------------------------------------------------
// word_string_hash_casefold_test
// Top of the string hash testbench. Feeds directed words around the detector
// and terminator corner cases, then random strings of varied length, with
// bursty input and a stalling output; the checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module word_string_hash_casefold_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_TARGET = 1800;
  localparam int IDLE_LIMIT  = 5000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_count;
  int   words_sent;
  int   burst_left;
  int   idle_cycles;
  logic [9:0] drain_phase = '0;

  wshc_in_if  in_ch ();
  wshc_out_if out_ch ();

  word_string_hash_casefold dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  wshc_hash_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (in_ch),
    .digest_i     (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #2ns clk_i = ~clk_i;

  // Receiver: always ready, light random stalls, a periodic stall, heavy stalls
  always @(posedge clk_i) begin
    drain_phase <= drain_phase + 10'd1;
    case (drain_phase[9:8])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ch.ready <= (drain_phase[2:0] < 3'd5);
      default: out_ch.ready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h5C;
      1:       return 8'h5B + 8'($urandom_range(0, 2));
      2:       return 8'h61 + 8'($urandom_range(0, 25));
      3:       return 8'h41 + 8'($urandom_range(0, 25));
      4:       return 8'h01;
      5:       return 8'hDC;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [31:0] body_word();
    logic [31:0] w;
    for (int i = 0; i < 4; i++) w[8*i +: 8] = text_byte();
    return w;
  endfunction

  // Zero in a random lane; lanes above it carry anything
  function automatic logic [31:0] closing_word();
    int          lane;
    logic [31:0] w;
    lane = $urandom_range(0, 3);
    w    = $urandom;
    for (int i = 0; i < lane; i++) w[8*i +: 8] = text_byte();
    w[8*lane +: 8] = 8'h00;
    return w;
  endfunction

  task automatic push_word(logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_ch.valid     <= 1'b0;
        in_ch.text_word <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.text_word <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  initial begin
    logic [31:0] directed_words[$];
    int          body_len;
    int          pick;
    in_ch.valid     <= 1'b0;
    in_ch.text_word <= '0;
    words_sent = 0;
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty strings, zero in every lane, backslash detector borrows, extremes
    directed_words = '{32'h0000_0000, 32'hFFFF_FF00, 32'h5C5C_5C5C, 32'h0000_005C,
                       32'hFFFF_FFFF, 32'h005C_5C5C, 32'h8080_8080, 32'h0101_0101,
                       32'h0101_0100, 32'h7A61_5A41, 32'h5D5C_5B5C, 32'h5C5D_5C5C,
                       32'h005C_5D5C, 32'h2F3A_5C63, 32'h0000_5C5C, 32'h5C00_FF5C,
                       32'hDDDC_DCDC, 32'h7F7F_7F7F, 32'h0000_0000, 32'hA0A0_A0A0,
                       32'h00DC_7C5C};
    foreach (directed_words[i]) push_word(directed_words[i]);

    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) body_len = $urandom_range(0, 4);
      else if (pick < 95) body_len = $urandom_range(5, 15);
      else body_len = $urandom_range(16, 60);
      for (int i = 0; i < body_len; i++) begin
        if ($urandom_range(0, 9) == 0) push_word($urandom);
        else push_word(body_word());
      end
      push_word(closing_word());
    end
    in_ch.valid <= 1'b0;

    // Let the last expectation land in the checker before draining
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/wshc_pkg.sv
rtl/core/wshc_in_if.sv
rtl/core/wshc_out_if.sv
rtl/core/wshc_fold.sv
rtl/core/word_string_hash_casefold.sv
tb/wshc_hash_checker.sv
tb/word_string_hash_casefold_test.sv
